// ----- hdl/dfa_token_scanner_assert.svh -----
// Assertion macros shared by the scanner modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DFA_TOKEN_SCANNER_ASSERT_SVH
`define DFA_TOKEN_SCANNER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define DTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dts_pkg.sv -----
package dts_pkg;

  // Default sizes of the scanner.
  localparam int unsigned     NumStatesDef  = 256;
  localparam int unsigned     NumTokensDef  = 256;
  localparam longint unsigned MaxTextLenDef = 64'd65536;

  // Depth of the step queue between the lookup pipeline and the match logic.
  localparam int unsigned QueueDepth = 4;

  // Commands on the input channel.
  typedef enum logic [1:0] {
    CmdWrTrans  = 2'd0,
    CmdWrAccept = 2'd1,
    CmdScan     = 2'd2,
    CmdUnused   = 2'd3
  } cmd_e;

  // Kinds of result on the output channel.
  typedef enum logic {
    KindMatch = 1'b0,
    KindEnd   = 1'b1
  } kind_e;

  // One scanned character after both table lookups.
  typedef struct packed {
    logic        fail;  // no transition existed
    logic        acc;   // the new state accepts
    logic [7:0]  tok;   // token of the new state
    logic [15:0] pos;   // offset of the character
    logic        last;  // final character of the text
  } step_t;

endpackage

// ----- hdl/dts_if.sv -----
// Input channel: one command per transaction.
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] state_index;
  logic [6:0] char_code;
  logic [7:0] next_state;
  logic       transition_ok;
  logic       is_accepting;
  logic [7:0] token_number;
  logic       last_char;

  modport source (
    output valid, command, state_index, char_code, next_state, transition_ok,
           is_accepting, token_number, last_char,
    input  ready
  );
  modport sink (
    input  valid, command, state_index, char_code, next_state, transition_ok,
           is_accepting, token_number, last_char,
    output ready
  );
endinterface

// Output channel: one result per transaction.
interface dts_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  match_token;
  logic [15:0] match_start;
  logic [15:0] match_length;
  logic        final_result;

  modport source (
    output valid, result_kind, match_token, match_start, match_length, final_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, match_token, match_start, match_length, final_result,
    output ready
  );
endinterface

// ----- hdl/dfa_token_scanner.sv -----
// DFA token scanner.
// Input channel in_i carries one command per transaction: a transition write,
// an accept-entry write, or one text character to scan. Load commands produce
// no result; a scanned character produces zero, one or two results on out_o.
// A token match reports token, start offset and length; the final character
// of a text is followed by an end marker, and final_result flags the last
// result caused by each character.
// Throughput is one transaction per cycle in steady state, while out_o takes
// results and the step queue has room. The transition table read sets that
// figure: the next state leaves the transition memory and addresses it again
// for the next character combinationally. A character that yields two results
// holds the match stage until its second result reaches the output register.
// A result passes the transition read at the accepting edge, the accept-table
// read, the write into the step queue, and the match stage loading the output.
// Reset clears the DFA state, scan offset and pending match; the tables come
// up undefined and must be loaded before use. When the receiver stalls, the
// output register holds its result, a four-entry step queue absorbs the
// characters in flight, and in_i.ready drops once the queue is committed.
module dfa_token_scanner #(
  parameter int unsigned     NUM_STATES   = dts_pkg::NumStatesDef,
  parameter int unsigned     NUM_TOKENS   = dts_pkg::NumTokensDef,
  parameter longint unsigned MAX_TEXT_LEN = dts_pkg::MaxTextLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dts_in_if.sink    in_i,
  dts_out_if.source out_o
);

  import dts_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Front to queue: one looked-up step per scanned character.
  logic            push;
  step_t           push_step;
  // Queue to back: the oldest step waiting for the match logic.
  logic            head_valid;
  step_t           head_step;
  logic            pop;
  // Queue occupancy, used by the front to reserve a slot before it accepts.
  logic [CntW-1:0] q_count;

  // The front owns both tables and the DFA state; it never stalls once a
  // character is accepted, because it only accepts with a queue slot free.
  dts_front #(
    .NUM_STATES   (NUM_STATES),
    .NUM_TOKENS   (NUM_TOKENS),
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .QUEUE_DEPTH  (QueueDepth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .count_i (q_count),
    .push_o  (push),
    .step_o  (push_step)
  );

  dts_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_step),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_step),
    .count_o (q_count)
  );

  // The back keeps the pending match and turns each step into results; it stalls
  // while a result is held, or for a step with results while the output is busy.
  dts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .step_i  (head_step),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- hdl/dts_ram.sv -----
module dts_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dts_front.sv -----
module dts_front #(
  parameter int unsigned     NUM_STATES   = dts_pkg::NumStatesDef,
  parameter int unsigned     NUM_TOKENS   = dts_pkg::NumTokensDef,
  parameter longint unsigned MAX_TEXT_LEN = dts_pkg::MaxTextLenDef,
  parameter int unsigned     QUEUE_DEPTH  = dts_pkg::QueueDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dts_in_if.sink                           in_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_i,
  output logic                             push_o,
  output dts_pkg::step_t                   step_o
);

  import dts_pkg::*;

  localparam int unsigned Rows       = (NUM_STATES < 256) ? NUM_STATES : 256;
  localparam int unsigned RowAw      = $clog2(Rows);
  localparam int unsigned TransDepth = Rows * 128;
  localparam int unsigned TransAw    = RowAw + 7;
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW:0] Cap      = (CntW + 1)'(QUEUE_DEPTH);
  localparam logic [16:0] WrapAt     = (MAX_TEXT_LEN >= 64'd65536) ? 17'h10000
                                                                   : 17'(MAX_TEXT_LEN);

  logic               accept;
  logic               is_scan;
  logic               trans_we;
  logic               acc_we;
  logic [TransAw-1:0] trans_waddr;
  logic [TransAw-1:0] trans_raddr;
  logic [8:0]         trans_rdata;
  logic [8:0]         acc_rdata;
  logic [7:0]         state_cur;
  logic [7:0]         state_q;
  logic [15:0]        pos_q;
  logic [16:0]        pos_inc;
  logic [15:0]        pos_next;
  logic [CntW:0]      in_flight;

  // Lookup pipeline: stage 1 waits for the transition word, stage 2 for the accept word.
  logic        p1_v_q, p2_v_q;
  logic [15:0] p1_pos_q, p2_pos_q;
  logic        p1_last_q, p2_last_q;
  logic        p2_fail_q;

  assign accept  = in_i.valid && in_i.ready;
  assign is_scan = accept && (in_i.command == CmdScan);

  assign trans_we = accept && (in_i.command == CmdWrTrans) &&
                    (32'(in_i.state_index) < NUM_STATES);
  assign acc_we   = accept && (in_i.command == CmdWrAccept) &&
                    (32'(in_i.state_index) < NUM_STATES) &&
                    (32'(in_i.token_number) < NUM_TOKENS);

  // Every scan in flight already owns a queue slot, so the pipeline never stalls.
  assign in_flight  = {1'b0, count_i} + (CntW + 1)'(p1_v_q) + (CntW + 1)'(p2_v_q);
  assign in_i.ready = in_flight < Cap;

  // The state for this cycle's lookup comes straight from the transition word
  // that the previous character read.
  always_comb begin
    state_cur = state_q;
    if (p1_v_q) begin
      state_cur = (p1_last_q || !trans_rdata[8]) ? 8'd0 : trans_rdata[7:0];
    end
  end

  assign trans_waddr = {in_i.state_index[RowAw-1:0], in_i.char_code};
  assign trans_raddr = {state_cur[RowAw-1:0], in_i.char_code};

  assign pos_inc  = {1'b0, pos_q} + 17'd1;
  assign pos_next = (pos_inc >= WrapAt) ? 16'd0 : pos_inc[15:0];

  dts_ram #(
    .WIDTH (9),
    .DEPTH (TransDepth)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (trans_waddr),
    .wdata_i ({in_i.transition_ok, in_i.next_state}),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rdata)
  );

  dts_ram #(
    .WIDTH (9),
    .DEPTH (Rows)
  ) u_accept_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (in_i.state_index[RowAw-1:0]),
    .wdata_i ({in_i.is_accepting, in_i.token_number}),
    .raddr_i (trans_rdata[RowAw-1:0]),
    .rdata_o (acc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      state_q <= 8'd0;
      pos_q   <= 16'd0;
    end else begin
      p1_v_q  <= is_scan;
      p2_v_q  <= p1_v_q;
      state_q <= state_cur;
      if (is_scan) begin
        pos_q <= in_i.last_char ? 16'd0 : pos_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_pos_q  <= pos_q;
    p1_last_q <= in_i.last_char;
    p2_pos_q  <= p1_pos_q;
    p2_last_q <= p1_last_q;
    p2_fail_q <= !trans_rdata[8];
  end

  assign push_o = p2_v_q;
  assign step_o = '{fail: p2_fail_q, acc: acc_rdata[8], tok: acc_rdata[7:0],
                    pos: p2_pos_q, last: p2_last_q};

endmodule

// ----- hdl/dts_queue.sv -----
module dts_queue #(
  parameter int unsigned DEPTH = dts_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  dts_pkg::step_t             data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output dts_pkg::step_t             data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  import dts_pkg::*;

`include "dfa_token_scanner_assert.svh"

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  step_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  `DTS_ASSERT(q_no_overflow, !(push_i && !pop_i && count_q == CntW'(DEPTH)), "step queue overflow")
  `DTS_ASSERT(q_no_underflow, !(pop_i && count_q == '0), "step queue underflow")
  `DTS_ASSERT_NEXT(q_push_seen, push_i && !pop_i, count_q != '0, "pushed step not visible")

endmodule

// ----- hdl/dts_back.sv -----
module dts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  dts_pkg::step_t step_i,
  output logic           pop_o,
  dts_out_if.source      out_o
);

  import dts_pkg::*;

`include "dfa_token_scanner_assert.svh"

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  token;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } res_t;

  // Stored length is one less than the match; the reported length saturates.
  function automatic res_t match_res(logic [7:0] tok, logic [15:0] start,
                                     logic [15:0] len_m1);
    res_t        r;
    logic [16:0] len;
    len      = {1'b0, len_m1} + 17'd1;
    r.kind   = KindMatch;
    r.token  = tok;
    r.start  = start;
    r.length = len[16] ? 16'hFFFF : len[15:0];
    r.last   = 1'b0;
    return r;
  endfunction

  localparam res_t EndRes = '{kind: KindEnd, token: 8'd0, start: 16'd0, length: 16'd0,
                              last: 1'b1};

  logic        pending_q, pending_d;
  logic [7:0]  best_q, best_d;
  logic [15:0] blen_q, blen_d;
  logic [15:0] tstart_q, tstart_d;
  logic [1:0]  n_res;
  res_t        r0, r1;
  logic        out_v_q, hold_v_q;
  res_t        out_q, hold_q;
  logic        out_free;
  logic        take;

  always_comb begin
    pending_d = pending_q;
    best_d    = best_q;
    blen_d    = blen_q;
    tstart_d  = tstart_q;
    r0        = EndRes;
    r1        = EndRes;
    n_res     = 2'd0;

    if (step_i.fail) begin
      if (pending_q) begin
        r0    = match_res(best_q, tstart_q, blen_q);
        n_res = 2'd1;
      end
      pending_d = 1'b0;
      tstart_d  = step_i.pos + 16'd1;
    end else if (step_i.acc && (!pending_q || step_i.tok <= best_q)) begin
      blen_d    = step_i.pos - tstart_q;
      best_d    = step_i.tok;
      pending_d = 1'b1;
    end

    if (step_i.last) begin
      if (n_res == 2'd1) begin
        n_res = 2'd2;
      end else if (pending_d) begin
        r0    = match_res(best_d, tstart_d, blen_d);
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end

    if (n_res == 2'd1) begin
      r0.last = 1'b1;
    end
  end

  assign out_free = !out_v_q || out_o.ready;
  assign take     = valid_i && !hold_v_q && ((n_res == 2'd0) || out_free);
  assign pop_o    = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      hold_v_q  <= 1'b0;
      pending_q <= 1'b0;
      best_q    <= 8'd0;
      blen_q    <= 16'd0;
      tstart_q  <= 16'd0;
    end else begin
      if (hold_v_q && out_free) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (take && (n_res != 2'd0)) begin
        out_v_q  <= 1'b1;
        hold_v_q <= (n_res == 2'd2);
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (take) begin
        if (step_i.last) begin
          pending_q <= 1'b0;
          best_q    <= 8'd0;
          blen_q    <= 16'd0;
          tstart_q  <= 16'd0;
        end else begin
          pending_q <= pending_d;
          best_q    <= best_d;
          blen_q    <= blen_d;
          tstart_q  <= tstart_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_v_q && out_free) begin
      out_q <= hold_q;
    end else if (take && (n_res != 2'd0)) begin
      out_q  <= r0;
      hold_q <= r1;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_kind  = out_q.kind;
  assign out_o.match_token  = out_q.token;
  assign out_o.match_start  = out_q.start;
  assign out_o.match_length = out_q.length;
  assign out_o.final_result = out_q.last;

  `DTS_ASSERT(hold_behind_out, !hold_v_q || out_v_q, "held result without a leading result")
  `DTS_ASSERT(hold_is_end, !hold_v_q || hold_q.kind == KindEnd, "held result is not end marker")
  `DTS_ASSERT(no_pop_on_hold, !(pop_o && hold_v_q), "step taken while a result is held")

endmodule
